### rtl/smeng_pkg.sv
`timescale 1ns / 1ps

package smeng_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_ORDER   = 4;

  localparam int ADDR_W     = $clog2(MAX_SAMPLES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int ORD_W      = 3;
  localparam int SAMPLE_W   = 16;
  localparam int MOM_W      = 32;
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int MEAN_W     = SAMPLE_W + 9;
  localparam int DMAG_W     = MEAN_W;
  localparam int LIMB_W     = 32;
  localparam int NLIMB      = 5;
  localparam int PROD_W     = LIMB_W * NLIMB;
  localparam int ACC_W      = 108;
  localparam int TGT_W      = ACC_W + 32;
  localparam int ROOT_W     = 32;
  localparam int BIT_W      = $clog2(ROOT_W);
  localparam int DIV_W      = ROOT_W + 16;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int LCNT_W     = $clog2(NLIMB);
  localparam int KK_W       = 3;

  localparam logic [ORD_W-1:0] ORD_ZERO  = ORD_W'(0);
  localparam logic [ORD_W-1:0] ORD_MEAN  = ORD_W'(1);
  localparam logic [ORD_W-1:0] ORD_STD   = ORD_W'(2);
  localparam logic [ORD_W-1:0] ORD_RESET = ORD_MEAN;

  localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [MOM_W-1:0] moment;
    logic                    saturated;
    logic                    overflowed;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MEAN,
    SEL_SIGMA,
    SEL_QUOT
  } out_sel_t;

  typedef struct packed {
    logic              load;
    logic              col_clr;
    logic              div_init_mean;
    logic              div_init_final;
    logic              div_step;
    logic              mean_set;
    logic              d_load;
    logic              mul_step;
    logic              mul_first;
    logic              b_cand;
    logic              acc_clr;
    logic              acc_add;
    logic              acc_odd;
    logic              tgt_load;
    logic [KK_W-1:0]   kk;
    logic              root_clr;
    logic              p_init_n;
    logic              root_cmp;
    logic [BIT_W-1:0]  bit_idx;
    logic              sigma_save;
    logic              out_load;
    out_sel_t          out_sel;
    logic [ADDR_W-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             root_zero;
  } sts_t;

endpackage

### rtl/smeng_ctrl.sv
`timescale 1ns / 1ps

module smeng_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_last,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      cfg_we,
  input  logic [smeng_pkg::ORD_W-1:0] cfg_data,
  input  smeng_pkg::sts_t           sts,
  output smeng_pkg::cmd_t           cmd
);
  import smeng_pkg::*;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_CLOSE = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_MEAN  = 14'b00000000001000,
    S_PRD   = 14'b00000000010000,
    S_PD    = 14'b00000000100000,
    S_PMUL  = 14'b00000001000000,
    S_PACC  = 14'b00000010000000,
    S_TGT   = 14'b00000100000000,
    S_RINIT = 14'b00001000000000,
    S_RMUL  = 14'b00010000000000,
    S_RCMP  = 14'b00100000000000,
    S_CHK   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(DIV_W - 1);
  localparam logic [LCNT_W-1:0] LIMB_LAST = LCNT_W'(NLIMB - 1);
  localparam logic [KK_W-1:0]   KK_STD    = KK_W'(2);

  state_t            state_r, state_nxt;
  logic [ORD_W-1:0]  ord_r;
  logic [KK_W-1:0]   kk_r, kk_nxt;
  logic              ph_r, ph_nxt;
  logic              fin_r, fin_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [LCNT_W-1:0] limb_r, limb_nxt;
  logic [KK_W-1:0]   mc_r, mc_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_sel_t          sel_r, sel_nxt;
  logic [KK_W-1:0]   ord_eff;
  logic              out_take;

  assign ord_eff   = (ord_r > ORD_W'(MAX_ORDER)) ? KK_W'(MAX_ORDER) : KK_W'(ord_r);
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_LOAD);

  always_comb begin
    state_nxt     = state_r;
    kk_nxt        = kk_r;
    ph_nxt        = ph_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    limb_nxt      = limb_r;
    mc_nxt        = mc_r;
    bit_nxt       = bit_r;
    dcnt_nxt      = dcnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r & ~out_take;
    cmd           = '0;
    cmd.kk        = kk_r;
    cmd.acc_odd   = kk_r[0];
    cmd.bit_idx   = bit_r;
    cmd.rd_addr   = idx_r;
    cmd.out_sel   = sel_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (ord_r == ORD_ZERO) begin
          sel_nxt   = SEL_ZERO;
          state_nxt = S_OUT;
        end else begin
          cmd.div_init_mean = 1'b1;
          fin_nxt           = 1'b0;
          dcnt_nxt          = '0;
          state_nxt         = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DIV_LAST) begin
          if (fin_r) begin
            sel_nxt   = SEL_QUOT;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        cmd.mean_set = 1'b1;
        if (ord_r == ORD_MEAN) begin
          sel_nxt   = SEL_MEAN;
          state_nxt = S_OUT;
        end else begin
          cmd.acc_clr = 1'b1;
          kk_nxt      = KK_STD;
          ph_nxt      = 1'b0;
          idx_nxt     = '0;
          state_nxt   = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PD;
      end
      S_PD: begin
        cmd.d_load = 1'b1;
        mc_nxt     = kk_r - KK_W'(1);
        limb_nxt   = '0;
        state_nxt  = S_PMUL;
      end
      S_PMUL: begin
        cmd.mul_step  = 1'b1;
        cmd.mul_first = (limb_r == '0);
        if (limb_r == LIMB_LAST) begin
          limb_nxt = '0;
          if (mc_r == KK_W'(1)) state_nxt = S_PACC;
          else mc_nxt = mc_r - KK_W'(1);
        end else begin
          limb_nxt = limb_r + LCNT_W'(1);
        end
      end
      S_PACC: begin
        cmd.acc_add = 1'b1;
        idx_nxt     = idx_r + ADDR_W'(1);
        if (CNT_W'(idx_r) + CNT_W'(1) == sts.cnt) state_nxt = S_TGT;
        else state_nxt = S_PRD;
      end
      S_TGT: begin
        cmd.tgt_load = 1'b1;
        cmd.root_clr = 1'b1;
        bit_nxt      = BIT_W'(ROOT_W - 1);
        state_nxt    = S_RINIT;
      end
      S_RINIT: begin
        cmd.p_init_n = 1'b1;
        mc_nxt       = kk_r;
        limb_nxt     = '0;
        state_nxt    = S_RMUL;
      end
      S_RMUL: begin
        cmd.mul_step  = 1'b1;
        cmd.mul_first = (limb_r == '0);
        cmd.b_cand    = 1'b1;
        if (limb_r == LIMB_LAST) begin
          limb_nxt = '0;
          if (mc_r == KK_W'(1)) state_nxt = S_RCMP;
          else mc_nxt = mc_r - KK_W'(1);
        end else begin
          limb_nxt = limb_r + LCNT_W'(1);
        end
      end
      S_RCMP: begin
        cmd.root_cmp = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = S_RINIT;
        end
      end
      S_CHK: begin
        if (!ph_r) begin
          cmd.sigma_save = 1'b1;
          if (ord_r == ORD_STD) begin
            sel_nxt   = SEL_SIGMA;
            state_nxt = S_OUT;
          end else if (sts.root_zero) begin
            sel_nxt   = SEL_ZERO;
            state_nxt = S_OUT;
          end else begin
            cmd.acc_clr = 1'b1;
            kk_nxt      = ord_eff;
            ph_nxt      = 1'b1;
            idx_nxt     = '0;
            state_nxt   = S_PRD;
          end
        end else begin
          cmd.div_init_final = 1'b1;
          fin_nxt            = 1'b1;
          dcnt_nxt           = '0;
          state_nxt          = S_DIV;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_take) begin
          cmd.out_load  = 1'b1;
          cmd.col_clr   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ord_r       <= ORD_RESET;
      kk_r        <= '0;
      ph_r        <= 1'b0;
      fin_r       <= 1'b0;
      idx_r       <= '0;
      limb_r      <= '0;
      mc_r        <= '0;
      bit_r       <= '0;
      dcnt_r      <= '0;
      sel_r       <= SEL_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) ord_r <= cfg_data;
      kk_r        <= kk_nxt;
      ph_r        <= ph_nxt;
      fin_r       <= fin_nxt;
      idx_r       <= idx_nxt;
      limb_r      <= limb_nxt;
      mc_r        <= mc_nxt;
      bit_r       <= bit_nxt;
      dcnt_r      <= dcnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/smeng_dp.sv
`timescale 1ns / 1ps

module smeng_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smeng_pkg::cmd_t      cmd,
  input  smeng_pkg::in_item_t  in_item,
  output smeng_pkg::sts_t      sts,
  output smeng_pkg::out_item_t out_item
);
  import smeng_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     drop_r, drop_nxt;
  logic                     ld_ok;

  logic signed [MEAN_W-1:0] mean_r, mean_nxt;
  logic                     sneg_r, sneg_nxt;
  logic [DMAG_W-1:0]        dmag_r, dmag_nxt;
  logic                     dneg_r, dneg_nxt;
  logic [PROD_W-1:0]        p_r, p_nxt;
  logic [LIMB_W-1:0]        carry_r, carry_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TGT_W-1:0]         tgt_r, tgt_nxt;
  logic [ROOT_W-1:0]        x_r, x_nxt;
  logic [ROOT_W-1:0]        sigma_r, sigma_nxt;
  logic [DIV_W-1:0]         dq_r, dq_nxt;
  logic [ROOT_W-1:0]        rem_r, rem_nxt;
  logic [ROOT_W-1:0]        dvs_r, dvs_nxt;
  out_item_t                out_r, out_nxt;

  logic [SUM_W-1:0]         smag;
  logic signed [MEAN_W:0]   dval;
  logic [ROOT_W-1:0]        cand;
  logic [LIMB_W-1:0]        mb, cin;
  logic [2*LIMB_W-1:0]      mprod;
  logic signed [ACC_W-1:0]  pv;
  logic [ACC_W-1:0]         aabs;
  logic [ROOT_W:0]          dtrial;
  logic                     dge;
  logic signed [MEAN_W+7:0] mv;
  logic signed [MEAN_W-1:0] qs;

  assign ld_ok        = (cnt_r < CNT_W'(MAX_SAMPLES));
  assign sts.cnt      = cnt_r;
  assign sts.root_zero = (x_r == '0);
  assign out_item     = out_r;

  // sample buffer
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) mem[cnt_r[ADDR_W-1:0]] <= in_item.sample;
    rd_data_r <= mem[cmd.rd_addr];
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    drop_nxt = drop_r;
    if (cmd.col_clr) begin
      cnt_nxt  = '0;
      sum_nxt  = '0;
      drop_nxt = 1'b0;
    end else if (cmd.load) begin
      if (ld_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_r + SUM_W'(in_item.sample);
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    smag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dval   = $signed({{2{rd_data_r[SAMPLE_W-1]}}, rd_data_r, 8'b0}) - (MEAN_W+1)'(mean_r);
    cand   = x_r | (ROOT_W'(1) << cmd.bit_idx);
    mb     = cmd.b_cand ? cand : LIMB_W'(dmag_r);
    cin    = cmd.mul_first ? '0 : carry_r;
    mprod  = {{LIMB_W{1'b0}}, p_r[LIMB_W-1:0]} * {{LIMB_W{1'b0}}, mb}
             + {{LIMB_W{1'b0}}, cin};
    pv     = $signed(p_r[ACC_W-1:0]);
    aabs   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    dtrial = {rem_r, dq_r[DIV_W-1]};
    dge    = (dtrial >= {1'b0, dvs_r});
    mv     = $signed({mean_r, 8'b0});
    qs     = $signed(dq_r[MEAN_W-1:0]);

    mean_nxt  = mean_r;
    sneg_nxt  = sneg_r;
    dmag_nxt  = dmag_r;
    dneg_nxt  = dneg_r;
    p_nxt     = p_r;
    carry_nxt = carry_r;
    acc_nxt   = acc_r;
    tgt_nxt   = tgt_r;
    x_nxt     = x_r;
    sigma_nxt = sigma_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    out_nxt   = out_r;

    // shared restoring divider
    if (cmd.div_init_mean) begin
      dq_nxt   = DIV_W'({smag, 9'b0}) + DIV_W'(cnt_r);
      dvs_nxt  = ROOT_W'({cnt_r, 1'b0});
      rem_nxt  = '0;
      sneg_nxt = sum_r[SUM_W-1];
    end else if (cmd.div_init_final) begin
      dq_nxt  = {x_r, 16'b0};
      dvs_nxt = sigma_r;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt = dge ? ROOT_W'(dtrial - {1'b0, dvs_r}) : dtrial[ROOT_W-1:0];
      dq_nxt  = {dq_r[DIV_W-2:0], dge};
    end

    if (cmd.mean_set) mean_nxt = sneg_r ? -qs : qs;

    // limb-serial multiplier
    if (cmd.d_load) begin
      dneg_nxt = dval[MEAN_W];
      dmag_nxt = dval[MEAN_W] ? DMAG_W'(-dval) : DMAG_W'(dval);
      p_nxt    = PROD_W'(dmag_nxt);
    end else if (cmd.p_init_n) begin
      p_nxt = PROD_W'(cnt_r);
    end else if (cmd.mul_step) begin
      p_nxt     = {mprod[LIMB_W-1:0], p_r[PROD_W-1:LIMB_W]};
      carry_nxt = mprod[2*LIMB_W-1:LIMB_W];
    end

    if (cmd.acc_clr) acc_nxt = '0;
    else if (cmd.acc_add) acc_nxt = (cmd.acc_odd && dneg_r) ? acc_r - pv : acc_r + pv;

    if (cmd.tgt_load) tgt_nxt = TGT_W'(aabs) << {cmd.kk, 3'b000};

    // root search, one bit per trial
    if (cmd.root_clr) x_nxt = '0;
    else if (cmd.root_cmp && (p_r <= PROD_W'(tgt_r))) x_nxt = cand;

    if (cmd.sigma_save) sigma_nxt = x_r;

    if (cmd.out_load) begin
      out_nxt.overflowed = drop_r;
      out_nxt.saturated  = 1'b0;
      out_nxt.moment     = '0;
      case (cmd.out_sel)
        SEL_ZERO: begin
          out_nxt.moment = '0;
        end
        SEL_MEAN: begin
          if (mv[MEAN_W+7] != mv[MEAN_W+6]) begin
            out_nxt.saturated = 1'b1;
            out_nxt.moment    = mv[MEAN_W+7] ? MOM_MIN : MOM_MAX;
          end else begin
            out_nxt.moment = mv[MOM_W-1:0];
          end
        end
        SEL_SIGMA: begin
          if (sigma_r[ROOT_W-1]) begin
            out_nxt.saturated = 1'b1;
            out_nxt.moment    = MOM_MAX;
          end else begin
            out_nxt.moment = $signed(sigma_r[MOM_W-1:0]);
          end
        end
        SEL_QUOT: begin
          if (|dq_r[DIV_W-1:MOM_W-1]) begin
            out_nxt.saturated = 1'b1;
            out_nxt.moment    = MOM_MAX;
          end else begin
            out_nxt.moment = $signed(dq_r[MOM_W-1:0]);
          end
        end
        default: begin
          out_nxt.moment = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_r  <= mean_nxt;
    sneg_r  <= sneg_nxt;
    dmag_r  <= dmag_nxt;
    dneg_r  <= dneg_nxt;
    p_r     <= p_nxt;
    carry_r <= carry_nxt;
    acc_r   <= acc_nxt;
    tgt_r   <= tgt_nxt;
    x_r     <= x_nxt;
    sigma_r <= sigma_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    out_r   <= out_nxt;
  end

endmodule

### rtl/sample_moment_engine.sv
`timescale 1ns / 1ps

// Collects one column of signed 16-bit samples (up to 1024, one item per
// cycle) and, after the item marked last, gives one statistic for the
// configured order: 0 zero, 1 mean, 2 population std deviation, 3 and up
// (above 4 treated as 4) the k-th root of the absolute k-th central moment
// over the std deviation, or zero if that is zero, all as signed Q16.16.
// Samples beyond 1024 are dropped and flagged on the result. Closing a
// column stalls the input while a sequencer runs a single 32x32 multiplier
// over five 32-bit limbs per wide multiply and a one-bit-per-cycle divider.
// A new column may load while the previous result still waits to be taken.
module sample_moment_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  smeng_pkg::in_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output smeng_pkg::out_item_t        out_item,
  input  logic                        cfg_we,
  input  logic [smeng_pkg::ORD_W-1:0] cfg_data
);
  import smeng_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smeng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  smeng_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

### rtl/smeng_checker.sv
`timescale 1ns / 1ps

module smeng_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input smeng_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input smeng_pkg::out_item_t out_item
);
  import smeng_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.last |=> in_stall)
    else $error("input not stalled after column close");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a close");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      (out_item.moment == MOM_MAX || out_item.moment == MOM_MIN))
    else $error("saturated result not at a limit");

endmodule

bind sample_moment_engine smeng_checker u_chk (.*);
